@@ src/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers shared by the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge out of reset.
`define ASSERT_ON(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition must never be seen at a clock edge out of reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  `ASSERT_ON(lbl, clk, rst_n, !(cond), msg)

`endif

@@ src/ftb_pkg.sv @@
// ----------------------------------------------------------------------------
// ftb_pkg
// Shared widths, command codes and helpers for the Fenwick tree block.
// ----------------------------------------------------------------------------
`default_nettype none

package ftb_pkg;

  localparam int unsigned DATA_W = 32;  // cell and sum width
  localparam int unsigned IDX_W  = 11;  // index fields
  localparam int unsigned SIZE_W = 11;  // size register
  localparam int unsigned KW     = 12;  // walk counter, holds up to 2x size

  localparam logic [SIZE_W-1:0] SIZE_RESET = 11'd1024;

  typedef enum logic [1:0] {
    CMD_ADD    = 2'd0,
    CMD_PREFIX = 2'd1,
    CMD_RANGE  = 2'd2
  } cmd_e;

  // Lowest set bit of a walk counter.
  function automatic logic [KW-1:0] low_bit(input logic [KW-1:0] k);
    return k & (~k + KW'(1));
  endfunction

endpackage

`default_nettype wire

@@ src/ftb_in_if.sv @@
// ----------------------------------------------------------------------------
// ftb_in_if
// Command channel: valid/ready handshake with one command beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface ftb_in_if;
  logic                                valid;
  logic                                ready;
  logic [1:0]                          command;
  logic [ftb_pkg::IDX_W-1:0]           index;
  logic [ftb_pkg::IDX_W-1:0]           index_end;
  logic signed [ftb_pkg::DATA_W-1:0]   delta;

  modport source (output valid, output command, output index, output index_end,
                  output delta, input ready);
  modport sink   (input valid, input command, input index, input index_end,
                  input delta, output ready);
endinterface

`default_nettype wire

@@ src/ftb_out_if.sv @@
// ----------------------------------------------------------------------------
// ftb_out_if
// Result channel: valid/ready handshake with one sum beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface ftb_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [ftb_pkg::DATA_W-1:0] total;

  modport source (output valid, output total, input ready);
  modport sink   (input valid, input total, output ready);
endinterface

`default_nettype wire

@@ src/fenwick_tree_add_and_prefix_sum.sv @@
// ----------------------------------------------------------------------------
// fenwick_tree_add_and_prefix_sum
// Binary indexed tree with point add, prefix sum and range sum commands.
// ----------------------------------------------------------------------------
// Partial sums live in two identical RAM copies (CAPACITY x 32) so a range
// query runs both prefix walks side by side. After reset the block sweeps
// the RAMs to zero, one cell per cycle, with in_i.ready low throughout
// (size writes still land). An add walks upward from index+1 doing a
// read-modify-write per cell, pipelined one cell per cycle; the walk covers
// at most 11 cells at size 1024. A prefix or range query strips the set bits
// of its two walk counts, reading one cell per set bit on each walk, and
// ends with a subtract of the two sums. A range whose two counts are both
// zero reads no cells. Results sit in an output register, so a new command
// can start while the previous sum waits to be taken; a query that ends
// while that sum still waits holds until the register frees. Adds at or
// beyond the size in use, and the unused command code, are dropped with no
// result. Sums wrap modulo 2^32.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module fenwick_tree_add_and_prefix_sum #(
  parameter int unsigned CAPACITY = 1024
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [ftb_pkg::SIZE_W-1:0] cfg_wdata_i,
  ftb_in_if.sink                     in_i,
  ftb_out_if.source                  out_o
);

  localparam int unsigned AddrW      = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned SizeW      = ftb_pkg::SIZE_W;
  localparam int unsigned KW         = ftb_pkg::KW;
  localparam int unsigned DW         = ftb_pkg::DATA_W;
  localparam int unsigned CapSizeInt = (CAPACITY > 2047) ? 2047 : CAPACITY;
  localparam logic [SizeW-1:0] CapSize  = SizeW'(CapSizeInt);
  localparam logic [AddrW-1:0] LastAddr = AddrW'(CAPACITY - 1);

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ADD,
    ST_QUERY
  } state_e;

  // control
  state_e            state_q;
  logic [AddrW-1:0]  clr_addr_q;
  logic [SizeW-1:0]  size_q;
  logic              pend_a_q, pend_b_q;   // read in flight on port A / B
  logic              out_valid_q;
  logic [DW-1:0]     total_q;

  // datapath
  logic [KW-1:0]     k_a_q, k_b_q;         // walk counters (1-based)
  logic [DW-1:0]     acc_a_q, acc_b_q;
  logic [DW-1:0]     delta_q;
  logic [AddrW-1:0]  wa_q;                 // cell read last cycle, add walk

  logic [SizeW-1:0]  live_n;
  logic [KW-1:0]     live_k, idx_k, end_k, idx_p1, pre_cnt, hi_cnt, lo_cnt;
  logic              in_fire, add_ok, issue_a, issue_b, query_done, out_free;
  logic              result_load;
  logic              ram_we;
  logic [AddrW-1:0]  ram_waddr, raddr_a, raddr_b;
  logic [DW-1:0]     ram_wdata, rdata_a, rdata_b;

  // --------------------------------------------------------------------------
  // Size clamp and command decode
  // --------------------------------------------------------------------------
  always_comb begin
    if (size_q == '0) begin
      live_n = SizeW'(1);
    end else if (size_q > CapSize) begin
      live_n = CapSize;
    end else begin
      live_n = size_q;
    end
    live_k  = KW'(live_n);
    idx_k   = KW'(in_i.index);
    end_k   = KW'(in_i.index_end);
    idx_p1  = idx_k + KW'(1);
    add_ok  = idx_k < live_k;
    pre_cnt = (idx_p1 > live_k) ? live_k : idx_p1;
    hi_cnt  = (end_k > live_k) ? live_k : end_k;
    lo_cnt  = (idx_k > live_k) ? live_k : idx_k;
  end

  assign in_fire  = in_i.valid && in_i.ready;
  assign out_free = !out_valid_q || out_o.ready;

  // Add walks up while k <= size; query walks strip bits down to zero.
  assign issue_a = (state_q == ST_ADD)   ? (k_a_q <= live_k) :
                   (state_q == ST_QUERY) ? (k_a_q != '0) : 1'b0;
  assign issue_b = (state_q == ST_QUERY) && (k_b_q != '0);

  assign query_done = (k_a_q == '0) && (k_b_q == '0) && !pend_a_q && !pend_b_q;

  // Finished query moves its sum into the output register.
  assign result_load = (state_q == ST_QUERY) && query_done && out_free;

  assign raddr_a = AddrW'(k_a_q - KW'(1));
  assign raddr_b = AddrW'(k_b_q - KW'(1));

  // Write port: clear sweep after reset, else the add writeback.
  always_comb begin
    if (state_q == ST_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr_q;
      ram_wdata = '0;
    end else begin
      ram_we    = (state_q == ST_ADD) && pend_a_q;
      ram_waddr = wa_q;
      ram_wdata = rdata_a + delta_q;
    end
  end

  // --------------------------------------------------------------------------
  // Cell store: two copies, written together, read independently
  // --------------------------------------------------------------------------
  ftb_ram #(.WIDTH(DW), .DEPTH(CAPACITY)) u_ram_a (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (raddr_a),
    .rdata_o (rdata_a)
  );

  ftb_ram #(.WIDTH(DW), .DEPTH(CAPACITY)) u_ram_b (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (raddr_b),
    .rdata_o (rdata_b)
  );

  // --------------------------------------------------------------------------
  // Sequencer: state, size register and result register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_addr_q  <= '0;
      size_q      <= ftb_pkg::SIZE_RESET;
      pend_a_q    <= 1'b0;
      pend_b_q    <= 1'b0;
      out_valid_q <= 1'b0;
      total_q     <= '0;
    end else begin
      if (cfg_we_i) begin
        size_q <= cfg_wdata_i;
      end
      if (result_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_CLEAR: begin
          clr_addr_q <= clr_addr_q + AddrW'(1);
          if (clr_addr_q == LastAddr) begin
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          pend_a_q <= 1'b0;
          pend_b_q <= 1'b0;
          if (in_fire) begin
            unique case (in_i.command) inside
              ftb_pkg::CMD_ADD: begin
                if (add_ok) begin
                  state_q <= ST_ADD;
                end
              end
              ftb_pkg::CMD_PREFIX,
              ftb_pkg::CMD_RANGE: state_q <= ST_QUERY;
              default: ;  // unused code: dropped
            endcase
          end
        end
        ST_ADD: begin
          pend_a_q <= issue_a;
          if (!issue_a && !pend_a_q) begin
            state_q <= ST_IDLE;
          end
        end
        ST_QUERY: begin
          pend_a_q <= issue_a;
          pend_b_q <= issue_b;
          if (result_load) begin
            total_q <= acc_a_q - acc_b_q;
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Walk counters and accumulators
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if ((state_q == ST_IDLE) && in_fire) begin
      delta_q <= $unsigned(in_i.delta);
      acc_a_q <= '0;
      acc_b_q <= '0;
      unique case (in_i.command)
        ftb_pkg::CMD_ADD: begin
          k_a_q <= idx_p1;
          k_b_q <= '0;
        end
        ftb_pkg::CMD_PREFIX: begin
          k_a_q <= pre_cnt;
          k_b_q <= '0;
        end
        ftb_pkg::CMD_RANGE: begin
          k_a_q <= hi_cnt;
          k_b_q <= lo_cnt;
        end
        default: ;
      endcase
    end else begin
      if (issue_a) begin
        wa_q <= raddr_a;
        if (state_q == ST_ADD) begin
          k_a_q <= k_a_q + ftb_pkg::low_bit(k_a_q);
        end else begin
          k_a_q <= k_a_q - ftb_pkg::low_bit(k_a_q);
        end
      end
      if (issue_b) begin
        k_b_q <= k_b_q - ftb_pkg::low_bit(k_b_q);
      end
      if ((state_q == ST_QUERY) && pend_a_q) begin
        acc_a_q <= acc_a_q + rdata_a;
      end
      if ((state_q == ST_QUERY) && pend_b_q) begin
        acc_b_q <= acc_b_q + rdata_b;
      end
    end
  end

  assign in_i.ready  = (state_q == ST_IDLE);
  assign out_o.valid = out_valid_q;
  assign out_o.total = $signed(total_q);

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `ASSERT_NEVER(a_no_write_in_query, clk_i, rst_ni,
                (state_q == ST_QUERY) && ram_we, "RAM write during query walk")
  `ASSERT_ON(a_query_in_range, clk_i, rst_ni,
             (state_q == ST_QUERY) |-> ((k_a_q <= live_k) && (k_b_q <= live_k)),
             "query walk counter beyond size")
  `ASSERT_ON(a_result_from_query, clk_i, rst_ni,
             $rose(out_valid_q) |-> $past(state_q == ST_QUERY),
             "result beat not launched by a query")

endmodule

`default_nettype wire

@@ src/ftb_ram.sv @@
// ----------------------------------------------------------------------------
// ftb_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module ftb_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire
